[hdl/nmea_sentence_checker_core_assert.svh]
// Assertion macros shared by the checker RTL.
`ifndef NMEA_SENTENCE_CHECKER_CORE_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define NSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define NSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/nsc_pkg.sv]
// Types, constants and helpers for the NMEA sentence checker.
package nsc_pkg;

	localparam int LINE_LIMIT_DEF = 1023;
	localparam int LEN_W          = 10;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_WAIT_PREFIX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_LEN    = 1'b1;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_FRAMING  = 2'd1,
		ST_CHECKSUM = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		KIND_LOX     = 3'd0,
		KIND_LOG     = 3'd1,
		KIND_ACK     = 3'd2,
		KIND_RELEASE = 3'd3,
		KIND_OTHER   = 3'd4
	} kind_t;

	// "$PMTKLOX", "$PMTKLOG", "$PMTK001", "$PMTK705", first char in low byte
	localparam logic [63:0] KIND_TAGS [4] = '{
		64'h584F4C4B544D5024,
		64'h474F4C4B544D5024,
		64'h3130304B544D5024,
		64'h3530374B544D5024
	};

	typedef struct packed {
		logic        long_enough;
		logic [63:0] head;
		logic [23:0] tail;
		logic [7:0]  xsum;
	} line_t;

	typedef struct packed {
		status_t    status;
		kind_t      kind;
		logic [7:0] computed_sum;
		logic [7:0] given_sum;
		logic       wait_hit;
	} verdict_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			h.val = 4'(c - 8'h30);
		end else if (c inside {[8'h41:8'h46]}) begin
			h.val = 4'(c - 8'h37);
		end else if (c inside {[8'h61:8'h66]}) begin
			h.val = 4'(c - 8'h57);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

[hdl/nmea_sentence_checker_core.sv]
// Top level of the NMEA sentence checker: line state, config and result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  in       | in_valid / in_ready | ch, end_of_line
//  out      | out_valid/out_ready | status, kind, computed_sum, given_sum,
//           |                     | wait_hit, line_length
//  cfg      | cfg_we              | cfg_index, cfg_data
//
// One item per cycle unless stalled. A character updates the line registers in
// the cycle it is taken; an end-of-line item loads the verdict into the result
// register, seen in the next cycle. in_ready falls only while a result is held
// unread. Reset clears the line and prefix registers and the result valid.
module nmea_sentence_checker_core #(
	parameter int LINE_LIMIT = nsc_pkg::LINE_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      ch,
	input  logic                            end_of_line,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [2:0]                      kind,
	output logic [7:0]                      computed_sum,
	output logic [7:0]                      given_sum,
	output logic                            wait_hit,
	output logic [nsc_pkg::LEN_W-1:0]       line_length,
	input  logic                            cfg_we,
	input  logic [nsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import nsc_pkg::*;

	`include "nmea_sentence_checker_core_assert.svh"

	localparam int CNT_W = $clog2(LINE_LIMIT + 1);

	logic [CNT_W-1:0]       cnt_q;
	logic [7:0]             xsum_q;
	logic [23:0]            tail_q;
	logic [63:0]            head_q;
	logic [63:0]            wait_prefix_q;
	logic [3:0]             wait_len_q;
	logic                   out_valid_q;
	verdict_t               verdict_q;
	logic [LEN_W-1:0]       len_q;

	logic                   in_fire;
	logic                   room;
	line_t                  line;
	verdict_t               verdict;
	logic [CNT_W+LEN_W-1:0] cnt_ext;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign room     = cnt_q < CNT_W'(LINE_LIMIT);
	assign cnt_ext  = {{LEN_W{1'b0}}, cnt_q};

	assign line.long_enough = cnt_q >= CNT_W'(4);
	assign line.head        = head_q;
	assign line.tail        = tail_q;
	assign line.xsum        = xsum_q;

	nsc_verdict u_verdict (
		.line        (line),
		.wait_prefix (wait_prefix_q),
		.wait_len    (wait_len_q),
		.verdict     (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_prefix_q <= '0;
			wait_len_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAIT_PREFIX: wait_prefix_q <= cfg_data;
				REG_WAIT_LEN:    wait_len_q    <= cfg_data[3:0];
				default:         ;
			endcase
		end
	end

	// line registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			xsum_q <= '0;
			tail_q <= '0;
			head_q <= '0;
		end else if (in_fire) begin
			if (end_of_line) begin
				cnt_q  <= '0;
				xsum_q <= '0;
				tail_q <= '0;
				head_q <= '0;
			end else if (room) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				tail_q <= {tail_q[15:0], ch};
				if (cnt_q != '0) begin
					xsum_q <= xsum_q ^ ch;
				end
				for (int i = 0; i < 8; i++) begin
					if (cnt_q == CNT_W'(i)) begin
						head_q[8*i +: 8] <= ch;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && end_of_line) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && end_of_line) begin
			verdict_q <= verdict;
			len_q     <= cnt_ext[LEN_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = verdict_q.status;
	assign kind         = verdict_q.kind;
	assign computed_sum = verdict_q.computed_sum;
	assign given_sum    = verdict_q.given_sum;
	assign wait_hit     = verdict_q.wait_hit;
	assign line_length  = len_q;

	`NSC_ASSERT_NEXT(a_eol_gives_item, clk, arst_n, in_fire && end_of_line,
		out_valid_q && (cnt_q == '0), "end of line did not yield an item or clear the line")
	`NSC_ASSERT_NOW(a_fault_is_other, clk, arst_n,
		out_valid_q && (verdict_q.status != ST_VALID),
		(verdict_q.kind == KIND_OTHER) && !verdict_q.wait_hit, "faulty line classed or hit")
	`NSC_ASSERT_NOW(a_framing_sums_zero, clk, arst_n,
		out_valid_q && (verdict_q.status == ST_FRAMING),
		(verdict_q.computed_sum == 8'd0) && (verdict_q.given_sum == 8'd0),
		"malformed line carries sums")
	`NSC_ASSERT_NOW(a_valid_sums_agree, clk, arst_n,
		out_valid_q && (verdict_q.status == ST_VALID),
		verdict_q.computed_sum == verdict_q.given_sum, "valid line with differing sums")
	`NSC_ASSERT_NEXT(a_count_steps, clk, arst_n, in_fire && !end_of_line && room,
		cnt_q == $past(cnt_q) + CNT_W'(1), "kept character not counted")

endmodule

[hdl/nsc_verdict.sv]
// End-of-line verdict: framing, checksum, sentence kind and prefix match.
module nsc_verdict (
	input  nsc_pkg::line_t    line,
	input  logic [63:0]       wait_prefix,
	input  logic [3:0]        wait_len,
	output nsc_pkg::verdict_t verdict
);
	import nsc_pkg::*;

	logic       framing_ok;
	hex_t       hi, lo;
	logic [7:0] csum;
	logic [7:0] gsum;
	logic       hit;
	kind_t      kind;

	assign framing_ok = line.long_enough && (line.head[7:0] == CH_DOLLAR)
		&& (line.tail[23:16] == CH_STAR);
	assign hi   = hex_decode(line.tail[15:8]);
	assign lo   = hex_decode(line.tail[7:0]);
	assign csum = line.xsum ^ line.tail[7:0] ^ line.tail[15:8] ^ line.tail[23:16];
	assign gsum = {hi.val, lo.val};

	// byte i counts only while i is below the compare length
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if ((wait_len > 4'(i)) && (line.head[8*i +: 8] != wait_prefix[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
	end

	always_comb begin
		kind = KIND_OTHER;
		for (int k = 3; k >= 0; k--) begin
			if (line.head == KIND_TAGS[k]) begin
				kind = kind_t'(3'(k));
			end
		end
	end

	always_comb begin
		verdict.status       = ST_FRAMING;
		verdict.kind         = KIND_OTHER;
		verdict.computed_sum = 8'd0;
		verdict.given_sum    = 8'd0;
		verdict.wait_hit     = 1'b0;
		if (framing_ok) begin
			verdict.computed_sum = csum;
			verdict.status       = ST_CHECKSUM;
			if (hi.ok && lo.ok) begin
				verdict.given_sum = gsum;
				if (gsum == csum) begin
					verdict.status   = ST_VALID;
					verdict.kind     = kind;
					verdict.wait_hit = hit;
				end
			end
		end
	end

endmodule

[test/testbench.sv]
// Self-checking testbench for nmea_sentence_checker_core against a line predictor.
`timescale 1ns / 100ps

module testbench;
	import nsc_pkg::*;

	localparam int LINE_CAP    = LINE_LIMIT_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 4;

	typedef struct packed {
		status_t     status;
		kind_t       kind;
		logic [7:0]  csum;
		logic [7:0]  gsum;
		logic        hit;
		logic [LEN_W-1:0] len;
	} line_verdict_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            ch;
	logic                  end_of_line;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            status;
	logic [2:0]            kind;
	logic [7:0]            computed_sum;
	logic [7:0]            given_sum;
	logic                  wait_hit;
	logic [LEN_W-1:0]      line_length;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nmea_sentence_checker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.ch           (ch),
		.end_of_line  (end_of_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.kind         (kind),
		.computed_sum (computed_sum),
		.given_sum    (given_sum),
		.wait_hit     (wait_hit),
		.line_length  (line_length),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// line predictor state and register copies
	int          line_cnt;
	logic [7:0]  line_xor;
	logic [23:0] line_tail;
	logic [63:0] line_head;
	logic [63:0] prefix_r;
	logic [3:0]  prefix_len_r;

	line_verdict_t verdicts_due[$];
	logic [7:0]    line_buf[$];
	string         tag_tails[4] = '{"PMTKLOX", "PMTKLOG", "PMTK001", "PMTK705"};

	int send_idle_pct;
	int stall_pct;
	logic hold_req;
	logic stall_hold;
	int mismatches;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			stall_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			stall_hold <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !stall_hold && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		line_verdict_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got.status = status_t'(status);
			got.kind   = kind_t'(kind);
			got.csum   = computed_sum;
			got.gsum   = given_sum;
			got.hit    = wait_hit;
			got.len    = line_length;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected item at %0t", $time);
					$display("  got st=%0d kind=%0d csum=%02h gsum=%02h hit=%0d len=%0d",
						got.status, got.kind, got.csum, got.gsum, got.hit, got.len);
				end
			end else begin
				want = verdicts_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t", $time);
						$display("  exp st=%0d kind=%0d csum=%02h gsum=%02h hit=%0d len=%0d",
							want.status, want.kind, want.csum, want.gsum, want.hit,
							want.len);
						$display("  got st=%0d kind=%0d csum=%02h gsum=%02h hit=%0d len=%0d",
							got.status, got.kind, got.csum, got.gsum, got.hit, got.len);
					end
				end
			end
		end
	end

	function automatic logic [63:0] head_of(string s);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			r[8*i +: 8] = s[i];
		return r;
	endfunction

	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	function automatic void take_char(logic [7:0] c);
		if (line_cnt < LINE_CAP) begin
			if (line_cnt >= 1)
				line_xor ^= c;
			if (line_cnt < 8)
				line_head[8*line_cnt +: 8] = c;
			line_tail = {line_tail[15:0], c};
			line_cnt++;
		end
	endfunction

	function automatic line_verdict_t judge_line();
		line_verdict_t v;
		int hi, lo, n;
		logic [63:0] mask;
		v.status = ST_FRAMING;
		v.kind   = KIND_OTHER;
		v.csum   = 8'h00;
		v.gsum   = 8'h00;
		v.hit    = 1'b0;
		v.len    = LEN_W'(line_cnt);
		if (line_cnt >= 4 && line_head[7:0] == CH_DOLLAR && line_tail[23:16] == CH_STAR) begin
			hi = nibble_of(line_tail[15:8]);
			lo = nibble_of(line_tail[7:0]);
			v.csum = line_xor ^ line_tail[7:0] ^ line_tail[15:8] ^ line_tail[23:16];
			if (hi < 0 || lo < 0) begin
				v.status = ST_CHECKSUM;
			end else begin
				v.gsum = 8'(hi * 16 + lo);
				if (v.gsum != v.csum) begin
					v.status = ST_CHECKSUM;
				end else begin
					v.status = ST_VALID;
					n = prefix_len_r > 8 ? 8 : prefix_len_r;
					mask = n >= 8 ? '1 : (64'd1 << (8 * n)) - 64'd1;
					v.hit = (line_head & mask) == (prefix_r & mask);
					if (line_head == head_of("$PMTKLOX")) v.kind = KIND_LOX;
					else if (line_head == head_of("$PMTKLOG")) v.kind = KIND_LOG;
					else if (line_head == head_of("$PMTK001")) v.kind = KIND_ACK;
					else if (line_head == head_of("$PMTK705")) v.kind = KIND_RELEASE;
				end
			end
		end
		line_cnt  = 0;
		line_xor  = '0;
		line_tail = '0;
		line_head = '0;
		return v;
	endfunction

	task automatic send_item(input logic [7:0] c, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		ch          <= c;
		end_of_line <= e;
		do @(posedge clk); while (!in_ready);
		if (e)
			verdicts_due.push_back(judge_line());
		else
			take_char(c);
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_item(line_buf[i], 1'b0);
		send_item(8'($urandom), 1'b1);
		line_buf.delete();
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WAIT_PREFIX)
			prefix_r = val;
		else
			prefix_len_r = val[3:0];
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 10) return 8'("0" + n);
		return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
	endfunction

	// appends '*' and the two digit sum of everything after the first char, spoiled unless good
	task automatic finish_sentence(input bit good, input bit lower);
		logic [7:0] x;
		x = '0;
		for (int i = 1; i < line_buf.size(); i++)
			x ^= line_buf[i];
		if (!good)
			x ^= 8'($urandom_range(255, 1));
		line_buf.push_back(CH_STAR);
		line_buf.push_back(hex_char(x[7:4], lower));
		line_buf.push_back(hex_char(x[3:0], lower));
	endtask

	function automatic logic [7:0] body_char();
		if ($urandom_range(99) < 85)
			return 8'($urandom_range(8'h7E, 8'h20));
		return 8'($urandom);
	endfunction

	task automatic test_framing();
		send_line();                       // empty line
		put_str("$*0");
		send_line();
		put_str("$*00");
		send_line();
		put_str("!AB");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$AB,CD");
		send_line();
		put_str("$");
		line_buf.push_back(8'h00);
		put_str("A");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$");
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		line_buf.push_back(8'h7F);
		line_buf.push_back(8'h01);
		finish_sentence(1'b1, 1'b0);
		send_line();
	endtask

	task automatic test_checksums();
		put_str("$GPGGA,1");
		finish_sentence(1'b1, 1'b1);
		send_line();
		put_str("$GPGGA,1");
		finish_sentence(1'b0, 1'b0);
		send_line();
		put_str("$AB*G1");
		send_line();
		put_str("$AB*1g");
		send_line();
		put_str("$*zz");                  // sum zero but digits not hex
		send_line();
	endtask

	task automatic test_kinds();
		put_str("$PMTKLOX,0");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$PMTKLOG,1,2");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$PMTK001,182,3");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$PMTK705,AXN");
		finish_sentence(1'b1, 1'b1);
		send_line();
		put_str("$PMTKLOY");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$PMTKLOX");
		finish_sentence(1'b0, 1'b0);
		send_line();
	endtask

	task automatic test_prefix_match();
		set_reg(REG_WAIT_PREFIX, head_of("$PMTKLOG"));
		set_reg(REG_WAIT_LEN, 64'd8);
		put_str("$PMTKLOG,3");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$PMTKLOX");
		finish_sentence(1'b1, 1'b0);
		send_line();
		put_str("$PMTKLOG");
		finish_sentence(1'b0, 1'b0);
		send_line();
		set_reg(REG_WAIT_LEN, 64'd5);
		put_str("$PMTKLOX");
		finish_sentence(1'b1, 1'b0);
		send_line();
		set_reg(REG_WAIT_PREFIX, head_of("$PMTKLOX"));
		set_reg(REG_WAIT_LEN, 64'd15);
		put_str("$PMTKLOX");
		finish_sentence(1'b1, 1'b0);
		send_line();
		set_reg(REG_WAIT_PREFIX, '1);
		set_reg(REG_WAIT_LEN, 64'd8);
		put_str("$PMTKLOX");
		finish_sentence(1'b1, 1'b0);
		send_line();
		set_reg(REG_WAIT_LEN, 64'd0);
		put_str("$XY");
		finish_sentence(1'b1, 1'b0);
		send_line();
		// line shorter than the prefix: missing head bytes read as zero
		set_reg(REG_WAIT_PREFIX, head_of("$A*41"));
		set_reg(REG_WAIT_LEN, 64'd8);
		put_str("$A");
		finish_sentence(1'b1, 1'b0);
		send_line();
	endtask

	// a full line of kept characters followed by characters that are dropped
	task automatic test_long_lines();
		line_buf.push_back(CH_DOLLAR);
		repeat (LINE_CAP - 4) line_buf.push_back(8'($urandom_range(8'h7E, 8'h20)));
		finish_sentence(1'b1, 1'b0);
		repeat (17) line_buf.push_back(8'($urandom));
		send_line();
	endtask

	task automatic build_random_line();
		int r, k, n;
		r = $urandom_range(99);
		if (r < 85) begin
			line_buf.push_back(CH_DOLLAR);
			k = $urandom_range(5);
			if (k < 4)
				put_str(tag_tails[k]);
			else if (k == 4)
				put_str("PMTK");
			n = $urandom_range(10);
			repeat (n) line_buf.push_back(body_char());
			finish_sentence($urandom_range(9) != 0, $urandom_range(1));
			if (r >= 70) begin
				case ($urandom_range(3))
					0: line_buf.delete(0);
					1: line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom);
					2: begin
						n = $urandom_range(line_buf.size() - 1);
						while (line_buf.size() > n) void'(line_buf.pop_back());
					end
					default: line_buf[line_buf.size() - 1 - $urandom_range(1)] = "g";
				endcase
			end
		end else begin
			if ($urandom_range(2) == 0)
				line_buf.push_back(CH_DOLLAR);
			n = $urandom_range(8);
			repeat (n) line_buf.push_back(8'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		int sent;
		int idle_pcts[4]  = '{0, 52, 0, 11};
		int stall_pcts[4] = '{0, 0, 52, 11};
		for (int p = 0; p < 4; p++) begin
			set_reg(REG_WAIT_PREFIX, $urandom_range(1) ? head_of({"$", tag_tails[$urandom_range(3)]})
				: {$urandom, $urandom});
			set_reg(REG_WAIT_LEN, {$urandom, 28'($urandom), 4'($urandom_range(15))});
			send_idle_pct = idle_pcts[p];
			stall_pct     = stall_pcts[p];
			if (p == 2)
				hold_req <= 1'b1;
			sent = 0;
			while (sent < 60) begin
				build_random_line();
				sent += line_buf.size() + 1;
				send_line();
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		ch            = '0;
		end_of_line   = 1'b0;
		out_ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		hold_req      = 1'b0;
		stall_hold    = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		mismatches    = 0;
		cycles        = 0;
		prefix_r      = '0;
		prefix_len_r  = '0;
		line_cnt      = 0;
		line_xor      = '0;
		line_tail     = '0;
		line_head     = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_framing();
		test_checksums();
		test_kinds();
		test_prefix_match();
		test_long_lines();
		test_random_traffic();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
